### rtl/rbu_pkg.sv
// Shared types, constants and helpers for the two-times bilinear upscaler.
`timescale 1ns / 1ps

package rbu_pkg;

    // Configuration port
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd480;

    // Output coordinate width and maximum words per input pixel
    localparam int COORD_W   = 12;
    localparam int MAX_WORDS = 4;
    localparam int CNT_W     = 3;

    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [CNT_W-1:0]   t_cnt;

    // One RGB pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Input word
    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_pix_in;

    // Output word
    typedef struct packed {
        t_coord     out_row;
        t_coord     out_col;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       run_last;
    } t_pix_out;

    // Floor average of one channel
    function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8:1];
    endfunction

    // Per-channel floor average of two pixels
    function automatic t_rgb avg_px(input t_rgb a, input t_rgb b);
        t_rgb r;
        r.red   = avg8(a.red,   b.red);
        r.green = avg8(a.green, b.green);
        r.blue  = avg8(a.blue,  b.blue);
        return r;
    endfunction

    // Assemble one output word
    function automatic t_pix_out mk_word(input t_coord row, input t_coord col,
                                         input t_rgb px, input logic last);
        t_pix_out w;
        w.out_row   = row;
        w.out_col   = col;
        w.out_red   = px.red;
        w.out_green = px.green;
        w.out_blue  = px.blue;
        w.run_last  = last;
        return w;
    endfunction

endpackage

### rtl/rbu_interp.sv
// Interpolation of one input pixel into its packed list of output words.
`timescale 1ns / 1ps

module rbu_interp
    import rbu_pkg::*;
(
    input  t_rgb     i_px,
    input  t_rgb     i_left,
    input  t_rgb     i_up,
    input  t_rgb     i_upleft,
    input  t_coord   i_row2,
    input  t_coord   i_col2,
    input  logic     i_has_left,
    input  logic     i_has_up,
    output t_pix_out o_words [MAX_WORDS],
    output t_cnt     o_count
);

    t_rgb   w_horiz;
    t_rgb   w_vert;
    t_rgb   w_above;
    t_rgb   w_centre;
    t_coord w_row1;
    t_coord w_col1;
    logic   w_both;

    // Neighbour averages; the centre goes through the two horizontal ones
    assign w_horiz  = avg_px(i_left, i_px);
    assign w_vert   = avg_px(i_up, i_px);
    assign w_above  = avg_px(i_upleft, i_up);
    assign w_centre = avg_px(w_above, w_horiz);

    assign w_row1 = i_row2 - t_coord'(1);
    assign w_col1 = i_col2 - t_coord'(1);
    assign w_both = i_has_left & i_has_up;

    assign o_count = t_cnt'(1) + t_cnt'(i_has_left) + t_cnt'(i_has_up) + t_cnt'(w_both);

    // Pack the words that exist, in emission order
    always_comb begin
        o_words[0] = mk_word(i_row2, i_col2, i_px, o_count == t_cnt'(1));
        if (i_has_left) begin
            o_words[1] = mk_word(i_row2, w_col1, w_horiz, o_count == t_cnt'(2));
        end else begin
            o_words[1] = mk_word(w_row1, i_col2, w_vert, o_count == t_cnt'(2));
        end
        o_words[2] = mk_word(w_row1, i_col2, w_vert, o_count == t_cnt'(3));
        o_words[3] = mk_word(w_row1, w_col1, w_centre, 1'b1);
    end

endmodule

### rtl/rgb_bilinear_upscale_x2_top.sv
// Top level of the two-times bilinear RGB upscaler.
//
//   port group   direction  handshake                 word
//   i_in_*       in         i_in_valid / o_in_ready   t_pix_in, one pixel, raster order
//   o_out_*      out        o_out_valid / i_out_ready t_pix_out, one upscaled pixel
//   i_cfg_*      in         i_cfg_we (no wait)        image_width, image_height
//
// Each input pixel makes one to four output words, by its position in the frame,
// four in the frame interior. The output port moves one word per cycle while
// i_out_ready is high. An accepted pixel passes the interpolation stage, then the list.
// Reset (i_rst_n low, synchronous) clears counters, neighbour pixels and stage
// valids and loads 640 by 480; the previous-row memory is not cleared.
// A stalled output holds the word list; input is taken while the list drains.
`timescale 1ns / 1ps

module rgb_bilinear_upscale_x2_top
    import rbu_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_pix_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_pix_out             o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = (WW > CFG_W) ? WW : CFG_W;
    localparam int HCW = (HW > CFG_W) ? HW : CFG_W;

    // Configuration registers
    logic [CFG_W-1:0] r_width_cfg;
    logic [CFG_W-1:0] r_height_cfg;

    // Position of the next input pixel and neighbour history
    logic [XW-1:0] r_x,  n_x;
    logic [YW-1:0] r_y,  n_y;
    t_rgb          r_left;
    t_rgb          r_upleft;

    // Previous-row memory
    t_rgb r_store [MAX_WIDTH];

    // Interpolation stage
    logic          r_s1_valid;
    t_rgb          r_s1_px;
    t_rgb          r_s1_left;
    t_rgb          r_s1_up;
    logic [XW-1:0] r_s1_x;
    logic [YW-1:0] r_s1_y;

    // Output word list
    t_pix_out r_q [MAX_WORDS];
    t_cnt     r_rem;

    logic [WW-1:0] w_width;
    logic [HW-1:0] w_height;
    logic [XW:0]   w_x_inc;
    logic [YW:0]   w_y_inc;
    t_rgb          w_px;
    logic          w_in_acc;
    logic          w_take;
    logic          w_s2_free;
    logic          w_load;
    t_pix_out      w_words [MAX_WORDS];
    t_cnt          w_count;

    // Clamp the frame size to one..maximum
    always_comb begin
        if (r_width_cfg == '0) begin
            w_width = WW'(1);
        end else if (WCW'(r_width_cfg) > WCW'(MAX_WIDTH)) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = WW'(r_width_cfg);
        end
        if (r_height_cfg == '0) begin
            w_height = HW'(1);
        end else if (HCW'(r_height_cfg) > HCW'(MAX_HEIGHT)) begin
            w_height = HW'(MAX_HEIGHT);
        end else begin
            w_height = HW'(r_height_cfg);
        end
    end

    // Handshakes
    assign w_take      = o_out_valid & i_out_ready;
    assign w_s2_free   = (r_rem == '0) | (w_take & (r_rem == t_cnt'(1)));
    assign w_load      = r_s1_valid & w_s2_free;
    assign o_in_ready  = ~r_s1_valid | w_load;
    assign w_in_acc    = i_in_valid & o_in_ready;
    assign o_out_valid = (r_rem != '0);
    assign o_out_data  = r_q[0];

    assign w_px = '{red: i_in_data.in_red, green: i_in_data.in_green,
                    blue: i_in_data.in_blue};

    // Advance the raster position, wrapping at row and frame end
    assign w_x_inc = {1'b0, r_x} + (XW+1)'(1);
    assign w_y_inc = {1'b0, r_y} + (YW+1)'(1);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (w_in_acc) begin
            if (w_x_inc >= (XW+1)'(w_width)) begin
                n_x = '0;
                if (w_y_inc >= (YW+1)'(w_height)) begin
                    n_y = '0;
                end else begin
                    n_y = w_y_inc[YW-1:0];
                end
            end else begin
                n_x = w_x_inc[XW-1:0];
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= RST_IMAGE_WIDTH;
            r_height_cfg <= RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_width_cfg  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state and neighbour history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_y        <= '0;
            r_left     <= '0;
            r_upleft   <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
            if (w_in_acc) begin
                r_left <= w_px;
            end
            if (w_load) begin
                r_upleft <= r_s1_up;
            end
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_load) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Capture the accepted pixel for interpolation
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_px   <= w_px;
            r_s1_left <= r_left;
            r_s1_x    <= r_x;
            r_s1_y    <= r_y;
        end
    end

    // Read the pixel above and overwrite it with this one
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_up        <= r_store[r_x];
            r_store[r_x]   <= w_px;
        end
    end

    rbu_interp u_interp (
        .i_px       (r_s1_px),
        .i_left     (r_s1_left),
        .i_up       (r_s1_up),
        .i_upleft   (r_upleft),
        .i_row2     (t_coord'({r_s1_y, 1'b0})),
        .i_col2     (t_coord'({r_s1_x, 1'b0})),
        .i_has_left (r_s1_x != '0),
        .i_has_up   (r_s1_y != '0),
        .o_words    (w_words),
        .o_count    (w_count)
    );

    // Word count of the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (w_load) begin
            r_rem <= w_count;
        end else if (w_take) begin
            r_rem <= r_rem - t_cnt'(1);
        end
    end

    // Load a fresh list or shift the taken word out
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_q <= w_words;
        end else if (w_take) begin
            for (int i = 0; i < MAX_WORDS - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
        end
    end

endmodule
